// ----- rtl/core/aes_ctr_pkg.sv -----
`timescale 1ns / 1ps
package aes_ctr_pkg;

  localparam int DataW    = 8;
  localparam int OffW     = 32;
  localparam int BlkW     = 28;
  localparam int RegW     = 64;
  localparam int CfgIdxW  = 2;
  localparam int Rounds   = 10;
  localparam int RndW     = 4;
  localparam int QDepth   = 4;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_KEY_LO = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_HI = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_IV_LO  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_IV_HI  = 2'd3;

  // request classified by the front end
  typedef struct packed {
    logic             miss;
    logic [BlkW-1:0]  blk;
    logic [3:0]       lane;
    logic [DataW-1:0] data;
  } req_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // next round key; byte i of the block in bits 8i+7:8i
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0]  w0, w1, w2, w3, g;
    logic [127:0] r;
    w0 = k[31:0]; w1 = k[63:32]; w2 = k[95:64]; w3 = k[127:96];
    g  = {sbox(w3[7:0]), sbox(w3[31:24]), sbox(w3[23:16]), sbox(w3[15:8]) ^ rc};
    w0 = w0 ^ g;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    r  = {w3, w2, w1, w0};
    return r;
  endfunction

  // one cipher round; last drops mix columns
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        t[c*4+w] = sbox(s[(((c + w) % 4) * 4 + w)*8 +: 8]);
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[i*8 +: 8] = t[i];
    end
    return r;
  endfunction

  function automatic logic [7:0] rcon(input logic [RndW-1:0] n);
    logic [7:0] v;
    case (n)
      4'd0:    v = 8'h01;
      4'd1:    v = 8'h02;
      4'd2:    v = 8'h04;
      4'd3:    v = 8'h08;
      4'd4:    v = 8'h10;
      4'd5:    v = 8'h20;
      4'd6:    v = 8'h40;
      4'd7:    v = 8'h80;
      4'd8:    v = 8'h1b;
      4'd9:    v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/aes_ctr_if.sv -----
`timescale 1ns / 1ps
interface aes_ctr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [31:0] byte_offset;
  modport source (output valid, data_byte, byte_offset, input ready);
  modport sink   (input valid, data_byte, byte_offset, output ready);
endinterface

interface aes_ctr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  modport source (output valid, out_byte, input ready);
  modport sink   (input valid, out_byte, output ready);
endinterface

interface aes_ctr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/aes_ctr_front.sv -----
`timescale 1ns / 1ps
module aes_ctr_front
  import aes_ctr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_hit,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0]  in_data,
  input  logic [31:0] in_off,
  output logic      q_valid,
  input  logic      q_ready,
  output req_t      q_req
);

  logic [$clog2(QDepth)-1:0] wp_r, rp_r;
  logic [$clog2(QDepth):0]   cnt_r;
  req_t                      mem_r [QDepth];
  logic [BlkW-1:0]           blk_r;
  logic                      vld_r;
  logic                      push, pop;
  req_t                      req;

  // classify: a new block or a stale cache needs a fresh keystream block
  always_comb begin
    req.blk  = in_off[OffW-1:4];
    req.lane = in_off[3:0];
    req.data = in_data;
    req.miss = !vld_r || (blk_r != in_off[OffW-1:4]);
  end

  assign in_ready = (cnt_r != ($clog2(QDepth)+1)'(QDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && q_ready;
  assign q_req    = mem_r[rp_r];

  // tag of the block the back end will hold
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      vld_r <= 1'b0;
      blk_r <= '0;
    end else if (push) begin
      vld_r <= 1'b1;
      blk_r <= req.blk;
    end
  end

  // request queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= req;
  end

endmodule

// ----- rtl/core/aes_ctr_back.sv -----
`timescale 1ns / 1ps
module aes_ctr_back
  import aes_ctr_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic [127:0]  key,
  input  logic [127:0]  iv,
  input  logic          q_valid,
  output logic          q_ready,
  input  req_t          q_req,
  output logic          o_valid,
  input  logic          o_ready,
  output logic [7:0]    o_byte
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t          st_r;
  logic [RndW-1:0] rnd_r;
  logic [127:0]    s_r, k_r, ks_r;
  logic [127:0]    knew;
  logic [127:0]    ks_nxt, ks_use;
  logic [63:0]     lo_sum;
  logic            lo_c;
  logic [63:0]     hi_sum;
  logic            ov_r;
  logic [7:0]      ob_r;
  logic            done, take;

  assign knew = key_next(k_r, rcon(rnd_r));
  assign {lo_c, lo_sum} = {1'b0, iv[63:0]} + {37'd0, q_req.blk};
  assign hi_sum = iv[127:64] + {63'd0, lo_c};

  // last round result, used directly by the miss that started the loop
  assign ks_nxt = aes_round(s_r, 1'b1) ^ knew;
  assign ks_use = done ? ks_nxt : ks_r;

  // a hit goes straight out; a miss runs the round loop and leaves at its end
  assign done    = (st_r == S_RUN) && (rnd_r == 4'(Rounds - 1)) && (!ov_r || o_ready);
  assign q_ready = ((st_r == S_IDLE) && !q_req.miss && (!ov_r || o_ready)) || done;
  assign take    = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      rnd_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (q_valid && q_req.miss) begin
            st_r  <= S_RUN;
            rnd_r <= '0;
          end
        end
        S_RUN: begin
          if (rnd_r != 4'(Rounds - 1)) rnd_r <= rnd_r + 1'b1;
          else if (done) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // round datapath, one round a cycle; the last round is held while the output register is full
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE) begin
      s_r <= {hi_sum, lo_sum} ^ key;
      k_r <= key;
    end else if (rnd_r != 4'(Rounds - 1)) begin
      s_r <= aes_round(s_r, 1'b0) ^ knew;
      k_r <= knew;
    end else if (done) begin
      ks_r <= ks_nxt;
    end
  end

  // output register; a miss leaves in the cycle its last round completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (take) begin
      ov_r <= 1'b1;
    end else if (o_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) ob_r <= q_req.data ^ ks_use[q_req.lane*8 +: 8];
  end

  assign o_valid = ov_r;
  assign o_byte  = ob_r;

endmodule

// ----- rtl/core/aes128_ctr_byte_cipher_unit.sv -----
`timescale 1ns / 1ps
// AES-128 counter-mode byte cipher. Each input request carries a byte and its
// stream position; the result is that byte XORed with byte (position mod 16)
// of AES-128(key, iv + position/16). A request in the same 16-byte block as
// the one before reuses the cached keystream block; a request in a new block
// first loads the counter, then runs ten rounds, one per cycle with the last
// held while the output register is full, and leaves as the last round
// completes. Writes to any key or iv register drop the cached block; write
// only when idle.
module aes128_ctr_byte_cipher_unit
  import aes_ctr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  aes_ctr_in_if.sink       in_ch,
  aes_ctr_out_if.source    out_ch,
  aes_ctr_cfg_if.sink      cfg_ch
);

  logic [RegW-1:0] key_lo_r, key_hi_r, iv_lo_r, iv_hi_r;
  logic            cfg_hit, q_valid, q_ready;
  req_t            q_req;

  assign cfg_ch.ready = 1'b1;
  assign cfg_hit = cfg_ch.valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= '0;
      key_hi_r <= '0;
      iv_lo_r  <= '0;
      iv_hi_r  <= '0;
    end else if (cfg_hit) begin
      case (cfg_ch.index)
        REG_KEY_LO: key_lo_r <= cfg_ch.data;
        REG_KEY_HI: key_hi_r <= cfg_ch.data;
        REG_IV_LO:  iv_lo_r  <= cfg_ch.data;
        REG_IV_HI:  iv_hi_r  <= cfg_ch.data;
        default:    key_lo_r <= key_lo_r;
      endcase
    end
  end

  aes_ctr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_hit  (cfg_hit),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (in_ch.data_byte),
    .in_off   (in_ch.byte_offset),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_req    (q_req)
  );

  aes_ctr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .key     ({key_hi_r, key_lo_r}),
    .iv      ({iv_hi_r, iv_lo_r}),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_req   (q_req),
    .o_valid (out_ch.valid),
    .o_ready (out_ch.ready),
    .o_byte  (out_ch.out_byte)
  );

  // a miss leaves only after waiting through the full round loop
  a_miss_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_req.miss && q_ready |-> $past(q_valid && q_req.miss, Rounds))
    else $error("miss request taken without keystream");

  // an output held back by the sink stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped");

endmodule

// ----- test/aes128_ctr_byte_cipher_unit_tb.sv -----
`timescale 1ns / 1ps
module aes128_ctr_byte_cipher_unit_tb;
  import aes_ctr_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 250;
  localparam int Phases     = 6;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

  typedef struct {
    logic [DataW-1:0] data;
    logic [OffW-1:0]  offset;
    bit               typed;
    logic [DataW-1:0] want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  aes_ctr_in_if  in_ch ();
  aes_ctr_out_if out_ch ();
  aes_ctr_cfg_if cfg_ch ();

  aes128_ctr_byte_cipher_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // shadow registers and keystream block of the predictor
  logic [RegW-1:0]  sh_key_lo, sh_key_hi, sh_iv_lo, sh_iv_hi;
  logic [127:0]     ks_block;
  logic [BlkW-1:0]  ks_index;
  bit               ks_valid;

  logic [DataW-1:0] expected_bytes [$];
  int unsigned      mismatches;
  int unsigned      results_seen;
  int unsigned      requests_sent;
  int unsigned      cycles;
  int unsigned      snd_idle, rcv_idle;
  bit               rcv_quiet;

  stim_row_t rows_reset [7] = '{
    '{8'h00, 32'h0000_0000, 1'b1, 8'h66},
    '{8'hff, 32'h0000_0000, 1'b1, 8'h99},
    '{8'h00, 32'h0000_000f, 1'b1, 8'h2e},
    '{8'h55, 32'h0000_0007, 1'b0, 8'h00},
    '{8'haa, 32'h0000_0010, 1'b0, 8'h00},
    '{8'h00, 32'hffff_ffff, 1'b0, 8'h00},
    '{8'hff, 32'hffff_fff0, 1'b0, 8'h00}
  };

  // iv all ones: block one wraps the whole counter back to zero
  stim_row_t rows_carry [6] = '{
    '{8'h00, 32'h0000_0000, 1'b0, 8'h00},
    '{8'h00, 32'h0000_0010, 1'b1, 8'h66},
    '{8'h00, 32'h0000_001f, 1'b1, 8'h2e},
    '{8'hff, 32'h0000_0011, 1'b0, 8'h00},
    '{8'h3c, 32'h8000_0020, 1'b0, 8'h00},
    '{8'hc3, 32'h7fff_ffff, 1'b0, 8'h00}
  };

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // aes-128 encryption; byte i of key and block in bits 8i+7:8i
  function automatic logic [127:0] aes_encrypt(input logic [127:0] k, input logic [127:0] pt);
    logic [7:0]   w [176];
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   g [4];
    logic [7:0]   first, a0, a1, a2, a3, al;
    logic [127:0] ct;
    for (int i = 0; i < 16; i++) w[i] = k[i*8 +: 8];
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) g[j] = w[i-4+j];
      if (i % 16 == 0) begin
        first = g[0];
        g[0] = SBOX[g[1]] ^ RCON[i/16-1];
        g[1] = SBOX[g[2]];
        g[2] = SBOX[g[3]];
        g[3] = SBOX[first];
      end
      for (int j = 0; j < 4; j++) w[i+j] = w[i-16+j] ^ g[j];
    end
    for (int i = 0; i < 16; i++) s[i] = pt[i*8 +: 8] ^ w[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[c*4+r] = SBOX[s[((c + r) % 4) * 4 + r]];
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[c*4]   = a0 ^ al ^ gf_double(a0 ^ a1);
          t[c*4+1] = a1 ^ al ^ gf_double(a1 ^ a2);
          t[c*4+2] = a2 ^ al ^ gf_double(a2 ^ a3);
          t[c*4+3] = a3 ^ al ^ gf_double(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ w[rnd*16+i];
    end
    for (int i = 0; i < 16; i++) ct[i*8 +: 8] = s[i];
    return ct;
  endfunction

  // cipher byte for a stream position (data XOR keystream byte), counter carry into the high word
  task automatic predict_cipher_byte(input logic [7:0] d, input logic [31:0] off,
                                     output logic [7:0] res);
    logic [BlkW-1:0] blk;
    logic [64:0]     lo_sum;
    logic [63:0]     hi;
    blk = off[31:4];
    if (!ks_valid || ks_index != blk) begin
      lo_sum = {1'b0, sh_iv_lo} + {37'd0, blk};
      hi = sh_iv_hi + {63'd0, lo_sum[64]};
      ks_block = aes_encrypt({sh_key_hi, sh_key_lo}, {hi, lo_sum[63:0]});
      ks_index = blk;
      ks_valid = 1'b1;
    end
    res = d ^ ks_block[off[3:0]*8 +: 8];
  endtask

  // clock, cycle limit
  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_bytes.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random back-pressure and comparison
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (expected_bytes.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result byte %02h", out_ch.out_byte);
      end else begin
        if (out_ch.out_byte !== expected_bytes[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("out_byte mismatch: expected %02h, got %02h",
                     expected_bytes[0], out_ch.out_byte);
        end
        void'(expected_bytes.pop_front());
      end
    end
    out_ch.ready <= rcv_quiet || ($urandom_range(0, 99) >= rcv_idle);
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_KEY_LO: sh_key_lo = val;
      REG_KEY_HI: sh_key_hi = val;
      REG_IV_LO:  sh_iv_lo  = val;
      REG_IV_HI:  sh_iv_hi  = val;
      default:    ;
    endcase
    ks_valid = 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_all(input logic [RegW-1:0] klo, input logic [RegW-1:0] khi,
                           input logic [RegW-1:0] ilo, input logic [RegW-1:0] ihi);
    wait_drained();
    write_reg(REG_KEY_LO, klo);
    write_reg(REG_KEY_HI, khi);
    write_reg(REG_IV_LO, ilo);
    write_reg(REG_IV_HI, ihi);
  endtask

  // one request, with an optional gap before it
  task automatic send_request(input logic [7:0] d, input logic [31:0] off, input bit typed,
                              input logic [7:0] want);
    logic [7:0] predicted;
    if ($urandom_range(0, 99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= d;
    in_ch.byte_offset <= off;
    do @(posedge clk); while (!in_ch.ready);
    predict_cipher_byte(d, off, predicted);
    expected_bytes.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [31:0] cur_off;
    int unsigned pick;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_offset = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_KEY_LO;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    results_seen = 0;
    requests_sent = 0;
    cycles = 0;
    rcv_quiet = 1'b0;
    snd_idle = 20;
    rcv_idle = 78;
    sh_key_lo = '0; sh_key_hi = '0; sh_iv_lo = '0; sh_iv_hi = '0;
    ks_valid = 1'b0; ks_index = '0; ks_block = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset key and counter, then the all-ones counter
    foreach (rows_reset[i])
      send_request(rows_reset[i].data, rows_reset[i].offset, rows_reset[i].typed,
                   rows_reset[i].want);
    in_ch.valid <= 1'b0;
    write_all('0, '0, '1, '1);
    foreach (rows_carry[i])
      send_request(rows_carry[i].data, rows_carry[i].offset, rows_carry[i].typed,
                   rows_carry[i].want);
    in_ch.valid <= 1'b0;

    // random phases: mostly sequential streams, some jumps within and across blocks
    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: write_all(rand64(), rand64(), rand64(), rand64());
        1: write_all('1, '1, 64'hffff_ffff_ffff_ff00 | $urandom_range(0, 255), rand64());
        2: write_all('0, '1, '1, 64'h0);
        default: write_all(rand64(), rand64(), rand64(), rand64());
      endcase
      snd_idle  = (ph / 2 == 0) ? 20 : (ph / 2 == 1) ? 78 : 0;
      rcv_idle  = (ph / 2 == 0) ? 78 : (ph / 2 == 1) ? 20 : 0;
      rcv_quiet = (ph / 2 == 2);
      cur_off = (ph % 2) ? (32'hffff_ffff - $urandom_range(0, 200)) : $urandom_range(0, 64);
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) cur_off = cur_off + 1;
        else if (pick < 90) cur_off = {cur_off[31:4], 4'($urandom_range(0, 15))};
        else if (pick < 97) cur_off = $urandom();
        else cur_off = 32'hffff_fff0 | $urandom_range(0, 15);
        send_request(8'($urandom_range(0, 255)), cur_off, 1'b0, 8'h00);
      end
      in_ch.valid <= 1'b0;
    end

    wait_drained();
    $display("%0d requests sent, %0d results checked over %0d register settings",
             requests_sent, results_seen, Phases + 2);
    $display("idle patterns: sender-heavy, receiver-heavy and none; counter carry and wrap");
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/aes_ctr_pkg.sv
rtl/core/aes_ctr_if.sv
rtl/core/aes_ctr_front.sv
rtl/core/aes_ctr_back.sv
rtl/core/aes128_ctr_byte_cipher_unit.sv
test/aes128_ctr_byte_cipher_unit_tb.sv
